/* design/prsa_pkg.sv */
// Package for the prime range sum and average block.
// Holds the field widths, the transaction payload structs and the
// controller-to-datapath command and status structs. Depends on nothing.
package prsa_pkg;

	localparam int FIELD_W        = 16;
	localparam int SUM_W          = 32;
	localparam int MEAN_W         = 23;
	localparam int SCALE          = 100;
	localparam int SCALE_W        = 7;
	localparam int VALUE_BITS_DEF = 16;

	typedef struct packed {
		logic [FIELD_W-1:0] first_bound;
		logic [FIELD_W-1:0] second_bound;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] prime_count;
		logic [SUM_W-1:0]   prime_sum;
		logic [MEAN_W-1:0]  mean_hundredths;
		logic               none_found;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_bounds;
		logic next_cand;
		logic init_trial;
		logic next_trial;
		logic add_prime;
		logic div_trial;
		logic div_mean;
		logic load_result;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cand_lt_upper;
		logic cand_ge_two;
		logic sq_le_cand;
		logic div_done;
		logic rem_zero;
		logic count_zero;
	} sts_t;

endpackage

/* design/prsa_divider.sv */
// Restoring serial divider, one quotient bit per cycle.
// Used for the trial division remainder and for the mean. Depends on prsa_pkg
// only through the module that instantiates it.
module prsa_divider #(
	parameter int DND_W  = 39,
	parameter int DVS_W  = 16,
	parameter int STEP_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DND_W-1:0]  dividend,
	input  logic [DVS_W-1:0]  divisor,
	input  logic [STEP_W-1:0] steps,
	output logic [DND_W-1:0]  quotient,
	output logic [DVS_W-1:0]  remainder,
	output logic              done
);

	logic [DND_W-1:0]  work_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DVS_W:0] trial_rem;
	logic [DVS_W:0] diff;
	logic           ge;

	assign trial_rem = {rem_q, work_q[DND_W-1]};
	assign ge        = trial_rem >= {1'b0, dvs_q};
	assign diff      = trial_rem - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DND_W-2:0], ge};
			rem_q  <= ge ? diff[DVS_W-1:0] : trial_rem[DVS_W-1:0];
		end
	end

	assign quotient  = work_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

/* design/prsa_datapath.sv */
// Datapath of the prime range block: candidate, trial divisor and its square,
// running sum and count, the shared serial divider and the result register.
// Depends on prsa_pkg and prsa_divider.
module prsa_datapath #(
	parameter int VALUE_BITS = prsa_pkg::VALUE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  prsa_pkg::req_t req,
	input  prsa_pkg::cmd_t cmd,
	output prsa_pkg::sts_t sts,
	output prsa_pkg::rsp_t rsp
);
	import prsa_pkg::*;

	localparam int W      = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
	localparam int DW     = SUM_W + SCALE_W;
	localparam int STEP_W = $clog2(DW + 1);

	logic [W-1:0]     upper_q;
	logic [W:0]       cand_q;
	logic [W-1:0]     d_q;
	logic [2*W:0]     sq_q;
	logic [SUM_W-1:0] sum_q;
	logic [W-1:0]     count_q;
	rsp_t             rsp_q;

	logic [W-1:0]      a;
	logic [W-1:0]      b;
	logic [DW-1:0]     mean_dividend;
	logic [DW-1:0]     dividend;
	logic [W-1:0]      divisor;
	logic [STEP_W-1:0] steps;
	logic [DW-1:0]     quotient;
	logic [W-1:0]      remainder;
	logic              div_done;

	assign a = req.first_bound[W-1:0];
	assign b = req.second_bound[W-1:0];

	// Mean in hundredths with round-half-up: (100 * sum + count / 2) / count.
	assign mean_dividend = DW'(sum_q) * DW'(SCALE) + DW'(count_q >> 1);

	always_comb begin
		if (cmd.div_mean) begin
			dividend = mean_dividend;
			divisor  = count_q;
			steps    = STEP_W'(DW);
		end else begin
			dividend = {cand_q[W-1:0], {(DW-W){1'b0}}};
			divisor  = d_q;
			steps    = STEP_W'(W);
		end
	end

	prsa_divider #(
		.DND_W  (DW),
		.DVS_W  (W),
		.STEP_W (STEP_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_trial || cmd.div_mean),
		.dividend  (dividend),
		.divisor   (divisor),
		.steps     (steps),
		.quotient  (quotient),
		.remainder (remainder),
		.done      (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_bounds) begin
			upper_q <= (a < b) ? b : a;
			cand_q  <= {1'b0, ((a < b) ? a : b)} + (W+1)'(1);
			sum_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.next_cand) begin
				cand_q <= cand_q + (W+1)'(1);
			end
			if (cmd.add_prime) begin
				sum_q   <= sum_q + SUM_W'(cand_q);
				count_q <= count_q + W'(1);
			end
		end
		if (cmd.init_trial) begin
			d_q  <= W'(2);
			sq_q <= (2*W+1)'(4);
		end else if (cmd.next_trial) begin
			// (d + 1)^2 = d^2 + 2d + 1
			sq_q <= sq_q + {{W{1'b0}}, d_q, 1'b1};
			d_q  <= d_q + W'(1);
		end
		if (cmd.load_result) begin
			rsp_q.prime_count     <= FIELD_W'(count_q);
			rsp_q.prime_sum       <= sum_q;
			rsp_q.mean_hundredths <= (count_q == '0) ? '0 : quotient[MEAN_W-1:0];
			rsp_q.none_found      <= (count_q == '0);
		end
	end

	assign sts.cand_lt_upper = cand_q < {1'b0, upper_q};
	assign sts.cand_ge_two   = cand_q >= (W+1)'(2);
	assign sts.sq_le_cand    = sq_q <= {{W{1'b0}}, cand_q};
	assign sts.div_done      = div_done;
	assign sts.rem_zero      = (remainder == '0);
	assign sts.count_zero    = (count_q == '0);

	assign rsp = rsp_q;

endmodule

/* design/prsa_ctrl.sv */
// Controller state machine of the prime range block: sequences the candidate
// scan, the trial divisions, the mean division and the result handoff.
// Depends on prsa_pkg.
module prsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  prsa_pkg::sts_t sts,
	output prsa_pkg::cmd_t cmd
);
	import prsa_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_TRIAL = 6'b000100,
		ST_DIVT  = 6'b001000,
		ST_DIVM  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_bounds = 1'b1;
					state_d         = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!sts.cand_lt_upper) begin
					if (sts.count_zero) begin
						state_d = ST_DONE;
					end else begin
						cmd.div_mean = 1'b1;
						state_d      = ST_DIVM;
					end
				end else if (!sts.cand_ge_two) begin
					cmd.next_cand = 1'b1;
				end else begin
					cmd.init_trial = 1'b1;
					state_d        = ST_TRIAL;
				end
			end
			ST_TRIAL: begin
				if (!sts.sq_le_cand) begin
					cmd.add_prime = 1'b1;
					cmd.next_cand = 1'b1;
					state_d       = ST_CHECK;
				end else begin
					cmd.div_trial = 1'b1;
					state_d       = ST_DIVT;
				end
			end
			ST_DIVT: begin
				if (sts.div_done) begin
					if (sts.rem_zero) begin
						cmd.next_cand = 1'b1;
						state_d       = ST_CHECK;
					end else begin
						cmd.next_trial = 1'b1;
						state_d        = ST_TRIAL;
					end
				end
			end
			ST_DIVM: begin
				if (sts.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	// The result register is never overwritten while it holds an untaken result.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten while still pending");

	// A divider completion is only expected while waiting on the divider.
	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_DIVT || state_q == ST_DIVM))
		else $error("divider finished outside a divide wait state");

	// An accepted request always starts the candidate scan.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_CHECK))
		else $error("accepted request did not start the scan");

endmodule

/* design/prime_range_sum_average.sv */
// Prime range sum and average: count, sum and rounded mean of primes between two bounds.
// Work per transaction: a W-bit trial division for each candidate and divisor tried, plus
// a DW-bit division for the mean, where W is the value width and DW is 39.
// One transaction at a time; the serial divider, at one bit a cycle, sets the pace.
// A new request is taken while a finished result still waits in the output register.
// Reset (arst_n, asynchronous, active low) clears the controller, divider control and valid.
module prime_range_sum_average #(
	parameter int VALUE_BITS = prsa_pkg::VALUE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  prsa_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output prsa_pkg::rsp_t rsp
);
	import prsa_pkg::*;

	// The controller and the datapath talk only through these two structs.
	cmd_t cmd;
	sts_t sts;

	// The controller walks every candidate strictly between the bounds. Values
	// below two are skipped, and each remaining candidate is tried against
	// divisors 2, 3, ... while the divisor squared does not exceed it, until one divides it.
	prsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the scan registers and a shared restoring divider that
	// serves both the remainder test and the final mean in hundredths.
	prsa_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

/* test/prime_range_sum_average_test.sv */
// Self-checking testbench for prime_range_sum_average.
// Depends on prsa_pkg for the request and response payload types and the
// scale factor. The expected count, sum and mean are worked out by the
// testbench itself, with trial division of its own.
`timescale 1ns / 100ps

module prime_range_sum_average_test;
	import prsa_pkg::*;

	// The block is slow, as each trial divisor costs a full serial division. The
	// watchdog counts cycles with no transaction on either side and ends the
	// run once WATCHDOG_LIMIT of them have passed.
	localparam int unsigned WATCHDOG_LIMIT = 1_000_000;
	// Cycles allowed after the last result, so that a stray extra response
	// still shows up as an unexpected one.
	localparam int unsigned TAIL_CYCLES    = 200;
	localparam int unsigned RANDOM_ITEMS   = 80;

	// One request waiting in the driver's queue. The gap is the number of
	// idle cycles after its transaction. When drain_first is set, the driver
	// holds the request back until every outstanding result has come.
	typedef struct {
		req_t        bounds;
		int unsigned gap_after;
		bit          drain_first;
	} pending_req_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	pending_req_t waiting_requests[$];
	rsp_t         awaited_results[$];

	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned gap_cnt      = 0;
	int unsigned stall_cnt    = 0;
	bit          req_taken    = 1'b0;
	bit          gappy        = 1'b0;
	bit          sink_calm    = 1'b0;

	prime_range_sum_average i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Idle length for either side. Most idles are short, but now and then a
	// long one lets the block run on for a good while undisturbed.
	function automatic int unsigned idle_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 4);
		else
			return $urandom_range(20, 150);
	endfunction

	// Computes the expected result for one pair of bounds. The bounds are
	// ordered first. Each value strictly between them that is at least two is
	// tested by trial division up to its square root. Sum and count are kept
	// wide, so the mean is exact before it is cut to its field width.
	function automatic rsp_t prime_stats(input req_t r);
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
		logic [31:0]        cand;
		logic [31:0]        div;
		logic [63:0]        total;
		logic [63:0]        count;
		logic [63:0]        avg;
		bit                 composite;
		rsp_t               res;
		lo    = (r.first_bound < r.second_bound) ? r.first_bound : r.second_bound;
		hi    = (r.first_bound < r.second_bound) ? r.second_bound : r.first_bound;
		total = '0;
		count = '0;
		for (cand = 32'(lo) + 1; cand < 32'(hi); cand++) begin
			if (cand >= 2) begin
				composite = 1'b0;
				for (div = 2; div * div <= cand && !composite; div++) begin
					if (cand % div == 0)
						composite = 1'b1;
				end
				if (!composite) begin
					total += 64'(cand);
					count += 1;
				end
			end
		end
		// The mean in hundredths is rounded to nearest, with halves going up.
		avg = (count != 0) ? (total * SCALE + count / 2) / count : '0;
		res.prime_count     = count[FIELD_W-1:0];
		res.prime_sum       = total[SUM_W-1:0];
		res.mean_hundredths = avg[MEAN_W-1:0];
		res.none_found      = (count == 0);
		return res;
	endfunction

	// Queues one request. The idle gap after it depends on whether the
	// current stretch of stimulus is a gappy one.
	task automatic queue_request(input int unsigned a, input int unsigned b, input bit drain);
		pending_req_t item;
		item.bounds.first_bound  = a[FIELD_W-1:0];
		item.bounds.second_bound = b[FIELD_W-1:0];
		item.gap_after           = gappy ? idle_length() : 0;
		item.drain_first         = drain;
		waiting_requests.push_back(item);
	endtask

	// Request driver. It works on the falling edge, so that the block sees
	// stable inputs at each rising edge. A presented request is held
	// unchanged until the monitor reports its transaction. Only then does
	// the driver count down the gap or present the next request.
	always @(negedge clk) begin : driver
		pending_req_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			gap_cnt   <= 0;
		end else if (!req_valid || req_taken) begin
			if (gap_cnt != 0) begin
				req_valid <= 1'b0;
				gap_cnt   <= gap_cnt - 1;
			end else if (waiting_requests.size() == 0 ||
				(waiting_requests[0].drain_first && awaited_results.size() != 0)) begin
				req_valid <= 1'b0;
			end else begin
				nxt       = waiting_requests.pop_front();
				req       <= nxt.bounds;
				req_valid <= 1'b1;
				gap_cnt   <= nxt.gap_after;
			end
		end
	end

	// Response sink. Its stalls come and go at random. Now and then the sink
	// switches between a calm mode, with ready held high, and a stalling one.
	// This way, back pressure meets the block both while it computes and while
	// a finished result waits.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (stall_cnt != 0) begin
			rsp_ready <= 1'b0;
			stall_cnt <= stall_cnt - 1;
		end else begin
			rsp_ready <= 1'b1;
			if (!sink_calm && $urandom_range(0, 3) == 0)
				stall_cnt <= idle_length();
		end
		if ($urandom_range(0, 399) == 0)
			sink_calm <= !sink_calm;
	end

	// Monitor. It samples at the rising edge, before the block's registers
	// update. Each accepted request adds its expected result to the queue.
	// Each accepted response is checked, field by field, against the oldest
	// expected result.
	always @(posedge clk) begin : monitor
		rsp_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_valid && req_ready;
			if (req_valid && req_ready)
				awaited_results.push_back(prime_stats(req));
			if (rsp_valid && rsp_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected response, expected none, got count %0d sum %0d",
						$time, rsp.prime_count, rsp.prime_sum);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (rsp.prime_count !== want.prime_count) begin
						$display("%0t: prime_count expected %0d, got %0d",
							$time, want.prime_count, rsp.prime_count);
						mismatches++;
					end
					if (rsp.prime_sum !== want.prime_sum) begin
						$display("%0t: prime_sum expected %0d, got %0d",
							$time, want.prime_sum, rsp.prime_sum);
						mismatches++;
					end
					if (rsp.mean_hundredths !== want.mean_hundredths) begin
						$display("%0t: mean_hundredths expected %0d, got %0d",
							$time, want.mean_hundredths, rsp.mean_hundredths);
						mismatches++;
					end
					if (rsp.none_found !== want.none_found) begin
						$display("%0t: none_found expected %0d, got %0d",
							$time, want.none_found, rsp.none_found);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog. It counts cycles in which no transaction happens on either
	// side. A hung handshake or a stuck computation ends the run here.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL prime_range_sum_average");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus and end of the run.
	initial begin : stimulus
		int unsigned lo;
		int unsigned hi;
		int unsigned span;
		int unsigned kind;

		// Directed part. These requests go back to back, so that a new request
		// arrives while the previous result still waits to be taken.
		gappy = 1'b0;
		queue_request(0, 0, 1'b0);             // equal bounds at zero
		queue_request(65535, 65535, 1'b0);     // equal bounds at the top
		queue_request(0, 1, 1'b0);             // only values below two
		queue_request(1, 0, 1'b0);
		queue_request(1, 2, 1'b0);
		queue_request(0, 2, 1'b0);             // one lies between, but it is not prime
		queue_request(0, 3, 1'b0);             // two is the only prime
		queue_request(3, 0, 1'b0);             // the same, bounds reversed
		queue_request(2, 3, 1'b0);             // adjacent bounds
		queue_request(5, 6, 1'b0);
		queue_request(2, 5, 1'b0);
		queue_request(20, 0, 1'b0);            // eight primes; the mean is exactly half way
		queue_request(0, 6, 1'b0);             // the mean rounds down
		queue_request(10, 20, 1'b0);
		queue_request(0, 100, 1'b0);
		queue_request(65535, 65520, 1'b0);     // the largest 16-bit prime
		queue_request(65534, 65535, 1'b0);
		queue_request(65400, 65535, 1'b0);
		queue_request(43690, 43710, 1'b0);
		queue_request(21860, 21845, 1'b0);
		queue_request(0, 1000, 1'b0);          // a large count and sum
		queue_request(32768, 32749, 1'b0);

		// Random part. Most ranges are short and sit at low values, where
		// trial division is cheap. Some have bounds anywhere in the field. A
		// few are wide. Each block of ten requests is gappy or not at random, gappy with odds of two in three.
		// The sender waits for every outstanding result before the first
		// random request and again half way through.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 10 == 0)
				gappy = ($urandom_range(0, 2) != 0);
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				lo   = $urandom_range(0, 1023);
				span = $urandom_range(0, 48);
			end else if (kind < 9) begin
				lo   = $urandom_range(0, 65535);
				span = $urandom_range(0, 16);
			end else begin
				lo   = $urandom_range(0, 4095);
				span = $urandom_range(0, 300);
			end
			hi = (lo + span > 65535) ? 65535 : lo + span;
			if ($urandom_range(0, 1) != 0)
				queue_request(lo, hi, n == 0 || n == RANDOM_ITEMS / 2);
			else
				queue_request(hi, lo, n == 0 || n == RANDOM_ITEMS / 2);
		end

		// Reset is held low from the start and is released at a falling edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every request has been taken and every result has come.
		while (waiting_requests.size() != 0 || req_valid)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("PASS prime_range_sum_average");
		else
			$display("FAIL prime_range_sum_average");
		$finish;
	end

endmodule

/* prime_range_sum_average.f */
design/prsa_pkg.sv
design/prsa_divider.sv
design/prsa_datapath.sv
design/prsa_ctrl.sv
design/prime_range_sum_average.sv
test/prime_range_sum_average_test.sv
